// ----- rtl/cfb_pkg.sv -----
// shared types and constants for the checksummed frame builder
`default_nettype none

package cfb_pkg;

   localparam int BUF_DEPTH_DEFAULT = 64;
   localparam int RESULT_CAP = 64;
   localparam int FILL_W = 7;
   localparam int LIMIT_W = 7;
   localparam int SUM_W = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [FILL_W-1:0] HEADER_LEN = 7'd5;
   localparam logic [7:0] SOF_BYTE = 8'hBB;
   localparam logic [7:0] EOF_BYTE = 8'h7E;
   localparam logic CSR_IDX_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      FUNC_BEGIN,
      FUNC_PUSH,
      FUNC_END,
      FUNC_NOP
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      func_type func;
      logic [7:0] data_byte;
      logic [7:0] group_len;
      logic group_first;
      logic [7:0] command;
      logic [7:0] info_kind;
   } req_type;

   typedef struct packed {
      logic status;
      logic [7:0] frame_byte;
      logic frame_valid;
      logic frame_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] op_a;
      logic [7:0] op_b;
      logic [7:0] op_c;
      logic [LIMIT_W-1:0] bound;
   } alu_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic below;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/cfb_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module cfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/cfb_alu.sv -----
// shared three-input adder with bound compare
`default_nettype none

module cfb_alu (
   input  wire cfb_pkg::alu_req_type req,
   output cfb_pkg::alu_rsp_type      rsp
);

   logic [cfb_pkg::SUM_W-1:0] sum;

   assign sum = cfb_pkg::SUM_W'(req.op_a) + cfb_pkg::SUM_W'(req.op_b)
              + cfb_pkg::SUM_W'(req.op_c);

   assign rsp.sum = sum;
   assign rsp.below = sum < cfb_pkg::SUM_W'(req.bound);

endmodule

`default_nettype wire

// ----- rtl/cfb_ctrl.sv -----
// sequencer and frame state for the frame builder
`default_nettype none

module cfb_ctrl #(
   parameter int BUF_DEPTH = cfb_pkg::BUF_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire cfb_pkg::req_type                 req_item,
   output logic                                  busy,
   input  wire logic [cfb_pkg::LIMIT_W-1:0]      limit,
   output cfb_pkg::alu_req_type                  alu_req,
   input  wire cfb_pkg::alu_rsp_type             alu_rsp,
   output logic                                  ram_we,
   output logic [$clog2(BUF_DEPTH)-1:0]          ram_waddr,
   output logic [7:0]                            ram_wdata,
   output logic [$clog2(BUF_DEPTH)-1:0]          ram_raddr,
   input  wire logic [7:0]                       ram_rdata,
   output logic                                  rsp_strobe,
   output cfb_pkg::rsp_type                      rsp_item
);

   localparam int ADDR_W = $clog2(BUF_DEPTH);
   localparam int FW = cfb_pkg::FILL_W;

   cfb_pkg::state_type state_ff, state_in;
   cfb_pkg::req_type item_ff, item_in;
   logic open_ff, open_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic ga_ff, ga_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [7:0] sum_ff, sum_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   cfb_pkg::rsp_type rsp_ff, rsp_in;

   logic [FW-1:0] plen;
   logic [FW-1:0] end_idx;
   logic emit_last;
   logic room;
   logic ok;
   logic store;

   assign plen = fill_ff - cfb_pkg::HEADER_LEN;
   assign end_idx = fill_ff + FW'(1);
   assign emit_last = idx_ff == end_idx;
   assign room = {2'b00, fill_ff} < 9'(BUF_DEPTH);
   assign ok = item_ff.group_first ? alu_rsp.below : (ga_ff && alu_rsp.below);
   assign store = ok && room;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfb_pkg::ST_IDLE: begin
            if (start) begin
               state_in = cfb_pkg::ST_EXEC;
            end
         end
         cfb_pkg::ST_EXEC: begin
            if (item_ff.func == cfb_pkg::FUNC_END && open_ff) begin
               state_in = cfb_pkg::ST_EMIT;
            end else begin
               state_in = cfb_pkg::ST_IDLE;
            end
         end
         cfb_pkg::ST_EMIT: begin
            if (emit_last) begin
               state_in = cfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      item_in = item_ff;
      open_in = open_ff;
      fill_in = fill_ff;
      ga_in = ga_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = '0;
      ram_we = 1'b0;
      alu_req.op_a = sum_ff;
      alu_req.op_b = ram_rdata;
      alu_req.op_c = 8'd0;
      alu_req.bound = limit;
      unique case (state_ff)
         cfb_pkg::ST_IDLE: begin
            if (start) begin
               item_in = req_item;
            end
         end
         cfb_pkg::ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_in.frame_last = 1'b1;
            unique case (item_ff.func)
               cfb_pkg::FUNC_BEGIN: begin
                  if (open_ff) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     open_in = 1'b1;
                     fill_in = cfb_pkg::HEADER_LEN;
                     ga_in = 1'b0;
                  end
               end
               cfb_pkg::FUNC_PUSH: begin
                  alu_req.op_a = 8'(fill_ff);
                  alu_req.op_b = item_ff.group_first ? item_ff.group_len : 8'd1;
                  alu_req.op_c = 8'd2;
                  if (!open_ff) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     ga_in = store;
                     rsp_in.status = !store;
                     if (store) begin
                        ram_we = 1'b1;
                        fill_in = fill_ff + FW'(1);
                     end
                  end
               end
               cfb_pkg::FUNC_END: begin
                  if (!open_ff) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     alu_req.op_a = item_ff.command;
                     alu_req.op_b = item_ff.info_kind;
                     alu_req.op_c = 8'(plen);
                     sum_in = alu_rsp.sum[7:0];
                     idx_in = '0;
                  end
               end
               cfb_pkg::FUNC_NOP: begin
                  rsp_in.status = 1'b0;
               end
               default: begin
                  rsp_in.status = 1'b0;
               end
            endcase
         end
         cfb_pkg::ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in.frame_valid = 1'b1;
            rsp_in.frame_last = emit_last;
            idx_in = idx_ff + FW'(1);
            if (idx_ff >= cfb_pkg::HEADER_LEN && idx_ff < fill_ff) begin
               sum_in = alu_rsp.sum[7:0];
            end
            priority if (idx_ff == FW'(0)) begin
               rsp_in.frame_byte = cfb_pkg::SOF_BYTE;
            end else if (idx_ff == FW'(1)) begin
               rsp_in.frame_byte = item_ff.command;
            end else if (idx_ff == FW'(2)) begin
               rsp_in.frame_byte = item_ff.info_kind;
            end else if (idx_ff == FW'(3)) begin
               rsp_in.frame_byte = 8'd0;
            end else if (idx_ff == FW'(4)) begin
               rsp_in.frame_byte = 8'(plen);
            end else if (idx_ff < fill_ff) begin
               rsp_in.frame_byte = ram_rdata;
            end else if (idx_ff == fill_ff) begin
               rsp_in.frame_byte = sum_ff;
            end else begin
               rsp_in.frame_byte = cfb_pkg::EOF_BYTE;
            end
            if (emit_last) begin
               open_in = 1'b0;
               ga_in = 1'b0;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfb_pkg::ST_IDLE;
         open_ff <= 1'b0;
         fill_ff <= '0;
         ga_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         fill_ff <= fill_in;
         ga_ff <= ga_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   assign busy = state_ff != cfb_pkg::ST_IDLE;
   assign ram_waddr = ADDR_W'(fill_ff);
   assign ram_wdata = item_ff.data_byte;
   assign ram_raddr = ADDR_W'(idx_in);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/checksummed_frame_builder.sv -----
// top level of the checksummed frame builder
//
// Begin, push, no-operation and rejected end transactions go through the
// cycle in which start is taken and one pass through the shared adder, with
// the single result shown in the cycle after that pass. A successful end has
// a set-up step that forms the header part of the checksum, then one frame
// byte per cycle, payload bytes read from the frame store, the running sum
// kept in the same shared adder. busy is high in the set-up and emit states,
// low again as the last result shows. Results carry no back-pressure: each
// is on rsp_item for the single cycle that rsp_strobe marks; frame bytes of
// one frame come in consecutive cycles. The store needs no clearing after reset.
`default_nettype none

module checksummed_frame_builder #(
   parameter int BUF_DEPTH = cfb_pkg::BUF_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire cfb_pkg::req_type                    req_item,
   output logic                                     rsp_strobe,
   output cfb_pkg::rsp_type                         rsp_item,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [cfb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [cfb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cfb_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   localparam int ADDR_W = $clog2(BUF_DEPTH);
   localparam int CAP = (BUF_DEPTH < cfb_pkg::RESULT_CAP) ? BUF_DEPTH : cfb_pkg::RESULT_CAP;
   localparam logic [cfb_pkg::LIMIT_W-1:0] CAP_LIMIT = cfb_pkg::LIMIT_W'(CAP);

   logic [cfb_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [cfb_pkg::LIMIT_W-1:0] limit_eff;
   logic csr_wr;

   cfb_pkg::alu_req_type alu_req;
   cfb_pkg::alu_rsp_type alu_rsp;
   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0] ram_rdata;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                && (paddr[cfb_pkg::CSR_ADDR_W-1] == cfb_pkg::CSR_IDX_LIMIT);
   assign limit_in = csr_wr ? pwdata[cfb_pkg::LIMIT_W-1:0] : limit_ff;
   assign limit_eff = (limit_ff > CAP_LIMIT) ? CAP_LIMIT : limit_ff;
   assign prdata = (paddr[cfb_pkg::CSR_ADDR_W-1] == cfb_pkg::CSR_IDX_LIMIT)
                 ? cfb_pkg::CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= cfb_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   cfb_ctrl #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_item(req_item),
      .busy(busy),
      .limit(limit_eff),
      .alu_req(alu_req),
      .alu_rsp(alu_rsp),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   cfb_alu u_alu (
      .req(alu_req),
      .rsp(alu_rsp)
   );

   cfb_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

endmodule

`default_nettype wire

// ----- rtl/cfb_checker.sv -----
// port-level checks for the checksummed frame builder
`default_nettype none

module cfb_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_strobe,
   input wire cfb_pkg::rsp_type                    rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a transaction was taken");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_strobe)
      else $error("result with no transaction in progress");

   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.frame_last |=> rsp_strobe && rsp_item.frame_valid)
      else $error("gap inside a frame");

   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status |-> rsp_item.frame_last && !rsp_item.frame_valid
         && rsp_item.frame_byte == 8'd0)
      else $error("malformed rejection result");

endmodule

bind checksummed_frame_builder cfb_checker u_cfb_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_item(rsp_item)
);

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the checksummed frame builder
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [cfb_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {cfb_pkg::CSR_IDX_LIMIT, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cfb_pkg::req_type req_item = '0;
   logic rsp_strobe;
   cfb_pkg::rsp_type rsp_item;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [cfb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cfb_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [cfb_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   cfb_pkg::req_type req_backlog[$];
   cfb_pkg::rsp_type result_due[$];

   logic frame_open = 1'b0;
   int fill_count = 0;
   logic group_ok = 1'b0;
   logic [7:0] frame_store[cfb_pkg::BUF_DEPTH_DEFAULT];
   logic [cfb_pkg::LIMIT_W-1:0] limit_reg = cfb_pkg::LIMIT_RESET;

   int gap_left = 0;
   logic steady = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   checksummed_frame_builder i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void due_result(logic st, logic [7:0] fbyte, logic fvalid, logic flast);
      cfb_pkg::rsp_type res;
      res.status = st;
      res.frame_byte = fbyte;
      res.frame_valid = fvalid;
      res.frame_last = flast;
      result_due.insert(result_due.size(), res);
   endfunction

   function automatic void compute_frame_results(cfb_pkg::req_type r);
      int lim;
      int k;
      logic ok;
      logic [15:0] plen;
      logic [7:0] sum;
      lim = (limit_reg > cfb_pkg::BUF_DEPTH_DEFAULT) ? cfb_pkg::BUF_DEPTH_DEFAULT
                                                     : int'(limit_reg);
      case (r.func)
         cfb_pkg::FUNC_BEGIN: begin
            if (frame_open) begin
               due_result(1'b1, 8'h00, 1'b0, 1'b1);
            end else begin
               frame_open = 1'b1;
               fill_count = int'(cfb_pkg::HEADER_LEN);
               group_ok = 1'b0;
               frame_store[0] = cfb_pkg::SOF_BYTE;
               due_result(1'b0, 8'h00, 1'b0, 1'b1);
            end
         end
         cfb_pkg::FUNC_PUSH: begin
            if (!frame_open) begin
               due_result(1'b1, 8'h00, 1'b0, 1'b1);
            end else begin
               if (r.group_first) begin
                  group_ok = (fill_count + int'(r.group_len) + 2 < lim);
                  ok = group_ok;
               end else begin
                  ok = group_ok && (fill_count + 3 < lim);
                  if (!ok) group_ok = 1'b0;
               end
               if (ok && fill_count < cfb_pkg::BUF_DEPTH_DEFAULT) begin
                  frame_store[fill_count] = r.data_byte;
                  fill_count = (fill_count + 1) & 'h7F;
                  due_result(1'b0, 8'h00, 1'b0, 1'b1);
               end else begin
                  group_ok = 1'b0;
                  due_result(1'b1, 8'h00, 1'b0, 1'b1);
               end
            end
         end
         cfb_pkg::FUNC_END: begin
            if (!frame_open) begin
               due_result(1'b1, 8'h00, 1'b0, 1'b1);
            end else begin
               plen = 16'(fill_count - int'(cfb_pkg::HEADER_LEN));
               due_result(1'b0, cfb_pkg::SOF_BYTE, 1'b1, 1'b0);
               due_result(1'b0, r.command, 1'b1, 1'b0);
               due_result(1'b0, r.info_kind, 1'b1, 1'b0);
               due_result(1'b0, plen[15:8], 1'b1, 1'b0);
               due_result(1'b0, plen[7:0], 1'b1, 1'b0);
               k = 5;
               sum = r.command + r.info_kind + plen[15:8] + plen[7:0];
               for (int i = int'(cfb_pkg::HEADER_LEN);
                    i < fill_count && i < cfb_pkg::BUF_DEPTH_DEFAULT; i++) begin
                  sum = sum + frame_store[i];
                  if (k < cfb_pkg::RESULT_CAP - 2) begin
                     due_result(1'b0, frame_store[i], 1'b1, 1'b0);
                     k++;
                  end
               end
               due_result(1'b0, sum, 1'b1, 1'b0);
               due_result(1'b0, cfb_pkg::EOF_BYTE, 1'b1, 1'b1);
               frame_open = 1'b0;
               group_ok = 1'b0;
            end
         end
         default: begin
            due_result(1'b0, 8'h00, 1'b0, 1'b1);
         end
      endcase
   endfunction

   // driver: holds start until the transaction is taken, then idles a random gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) compute_frame_results(req_item);
         if (!(start && busy)) begin
            if (gap_left != 0) begin
               start <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (req_backlog.size() != 0) begin
               req_item <= req_backlog.pop_front();
               start <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cfb_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (result_due.size() == 0) begin
            if (error_count < 10) begin
               $display("unexpected result: status %0d byte %02h valid %0d last %0d",
                        rsp_item.status, rsp_item.frame_byte, rsp_item.frame_valid,
                        rsp_item.frame_last);
            end
            error_count++;
         end else begin
            want = result_due.pop_front();
            if (rsp_item.status !== want.status || rsp_item.frame_byte !== want.frame_byte ||
                rsp_item.frame_valid !== want.frame_valid ||
                rsp_item.frame_last !== want.frame_last) begin
               if (error_count < 10) begin
                  $display("mismatch: expected status %0d byte %02h valid %0d last %0d",
                           want.status, want.frame_byte, want.frame_valid, want.frame_last);
                  $display("          got      status %0d byte %02h valid %0d last %0d",
                           rsp_item.status, rsp_item.frame_byte, rsp_item.frame_valid,
                           rsp_item.frame_last);
               end
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[checksummed_frame_builder] ERROR");
         $finish;
      end
   end

   function automatic cfb_pkg::req_type make_req(cfb_pkg::func_type f);
      cfb_pkg::req_type item;
      item.func = f;
      item.data_byte = 8'($urandom_range(0, 255));
      item.group_len = 8'($urandom_range(1, 255));
      item.group_first = 1'($urandom_range(0, 1));
      item.command = 8'($urandom_range(0, 255));
      item.info_kind = 8'($urandom_range(0, 255));
      return item;
   endfunction

   task automatic put_req(cfb_pkg::func_type f, logic [7:0] d, logic [7:0] glen, logic first,
                          logic [7:0] cmd, logic [7:0] info);
      cfb_pkg::req_type item;
      item.func = f;
      item.data_byte = d;
      item.group_len = glen;
      item.group_first = first;
      item.command = cmd;
      item.info_kind = info;
      req_backlog.insert(req_backlog.size(), item);
   endtask

   task automatic wait_idle();
      while (!(req_backlog.size() == 0 && !start && result_due.size() == 0 && !busy))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [cfb_pkg::LIMIT_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LIMIT_ADDR;
      pwdata <= cfb_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      limit_reg = value;
   endtask

   task automatic queue_frame(inout int added);
      int groups;
      int glen;
      int nbytes;
      int r;
      cfb_pkg::req_type item;
      req_backlog.insert(req_backlog.size(), make_req(cfb_pkg::FUNC_BEGIN));
      added++;
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (groups) begin
         r = $urandom_range(0, 99);
         if (r < 60) glen = $urandom_range(1, 4);
         else if (r < 85) glen = $urandom_range(5, 16);
         else if (r < 95) glen = $urandom_range(17, 40);
         else glen = $urandom_range(41, 255);
         nbytes = (glen > 40) ? $urandom_range(1, 3) : glen;
         r = $urandom_range(0, 9);
         if (r == 0) nbytes = $urandom_range(1, nbytes);
         else if (r == 1) nbytes += $urandom_range(1, 2);
         for (int i = 0; i < nbytes; i++) begin
            item = make_req(cfb_pkg::FUNC_PUSH);
            item.group_len = 8'(glen);
            item.group_first = (i == 0);
            req_backlog.insert(req_backlog.size(), item);
         end
         added += nbytes;
         if ($urandom_range(0, 19) == 0) begin
            req_backlog.insert(req_backlog.size(),
                               make_req(cfb_pkg::func_type'($urandom_range(0, 3))));
            added++;
         end
      end
      req_backlog.insert(req_backlog.size(), make_req(cfb_pkg::FUNC_END));
      added++;
   endtask

   task automatic run_phase(logic [cfb_pkg::LIMIT_W-1:0] value, int target);
      int added = 0;
      wait_idle();
      write_limit(value);
      steady = ($urandom_range(0, 3) == 0);
      while (added < target) begin
         if ($urandom_range(0, 9) < 7) begin
            queue_frame(added);
         end else begin
            req_backlog.insert(req_backlog.size(),
                               make_req(cfb_pkg::func_type'($urandom_range(0, 3))));
            added++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed transactions at the reset limit
      put_req(cfb_pkg::FUNC_END, 8'h00, 8'd1, 1'b0, 8'hFF, 8'hFF);
      put_req(cfb_pkg::FUNC_PUSH, 8'hFF, 8'd1, 1'b1, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_NOP, 8'h00, 8'd1, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_BEGIN, 8'h00, 8'd1, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_BEGIN, 8'hFF, 8'd255, 1'b1, 8'hFF, 8'hFF);
      put_req(cfb_pkg::FUNC_END, 8'h00, 8'd1, 1'b0, 8'h00, 8'hFF);
      put_req(cfb_pkg::FUNC_BEGIN, 8'h00, 8'd1, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h00, 8'd3, 1'b1, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'hFF, 8'd3, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'hA5, 8'd3, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h5A, 8'd3, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h01, 8'd255, 1'b1, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h02, 8'd255, 1'b0, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h80, 8'd1, 1'b1, 8'h00, 8'h00);
      put_req(cfb_pkg::FUNC_PUSH, 8'h7F, 8'd56, 1'b1, 8'hFF, 8'hFF);
      put_req(cfb_pkg::FUNC_END, 8'h00, 8'd1, 1'b0, 8'hFF, 8'h00);
      put_req(cfb_pkg::FUNC_NOP, 8'hFF, 8'd255, 1'b1, 8'hFF, 8'hFF);
      put_req(cfb_pkg::FUNC_END, 8'hFF, 8'd255, 1'b1, 8'h00, 8'h00);

      run_phase(7'd8, 15);
      run_phase(7'd3, 15);
      run_phase(7'd127, 20);
      run_phase(7'd64, 25);
      repeat (4) run_phase(7'($urandom_range(9, 63)), 15);
      run_phase(7'd20, 15);

      wait_idle();
      if (error_count == 0 && result_due.size() == 0) begin
         $display("[checksummed_frame_builder] OK");
      end else begin
         $display("[checksummed_frame_builder] ERROR");
      end
      $finish;
   end

endmodule

// ----- checksummed_frame_builder.f -----
rtl/cfb_pkg.sv
rtl/cfb_ram.sv
rtl/cfb_alu.sv
rtl/cfb_ctrl.sv
rtl/checksummed_frame_builder.sv
rtl/cfb_checker.sv
test/testbench.sv
